/* hdl/polynomial_add_sub_multiply_unit_assert.svh */
// assertion macros shared by the checker of the polynomial unit
// no dependencies; expects clk and rst in the scope of use
`ifndef POLYNOMIAL_ADD_SUB_MULTIPLY_UNIT_ASSERT_SVH
`define POLYNOMIAL_ADD_SUB_MULTIPLY_UNIT_ASSERT_SVH

// condition now implies a consequence in the same cycle
`define PASMU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition now implies a consequence in the next cycle
`define PASMU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/pasmu_pkg.sv */
// shared constants, widths and controller/datapath interface types
// of the polynomial add, subtract and multiply unit; no dependencies
`timescale 1ns / 1ps

package pasmu_pkg;

  localparam int TOP_DEGREE = 15;
  localparam int DEPTH      = TOP_DEGREE + 1;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int K_W        = $clog2(2 * TOP_DEGREE + 2);
  localparam int T_W        = K_W + 1;

  localparam int COEF_W = 16;
  localparam int IDX_W  = 5;
  localparam int SUM_W  = 17;
  localparam int PROD_W = 2 * COEF_W;
  localparam int ACC_W  = 36;

  localparam int OUT_FIELD_W = IDX_W + 2 * SUM_W + ACC_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_DATA_W - OUT_FIELD_W;

  // selector values on the input tuser
  localparam logic CMD_A = 1'b0;
  localparam logic CMD_B = 1'b1;

  typedef struct packed {
    logic wr_a;      // store a coefficient of a
    logic new_a;     // this a coefficient starts a fresh pair
    logic wr_b;      // store a coefficient of b
    logic k_init;    // first power of a new emission
    logic sum_rd;    // read a[k] and b[k]
    logic mac_rd;    // read a[i] and b[k-i]
    logic out_load;  // move finished result into the output register
    logic k_step;    // advance to the next power
    logic clear;     // emission done, drop both polynomials
  } pasmu_cmd_t;

  typedef struct packed {
    logic mac_last;  // current term is the last one of this power
    logic pipe_busy; // products still in flight
    logic final_k;   // current power is the highest one
  } pasmu_stat_t;

endpackage

/* hdl/pasmu_ctrl.sv */
// controller state machine: input acceptance, emission sequencing, output valid
// depends on pasmu_pkg
`timescale 1ns / 1ps

module pasmu_ctrl import pasmu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_sel,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  input  pasmu_stat_t stat,
  output pasmu_cmd_t  cmd
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       a_complete;
  logic       a_complete_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_LOAD);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    a_complete_next = a_complete;
    out_valid_next  = out_valid && !out_ready;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          if (in_sel == CMD_A) begin
            cmd.wr_a        = 1'b1;
            cmd.new_a       = a_complete;
            a_complete_next = in_last;
          end else if (a_complete) begin
            // b before a is closed is dropped
            cmd.wr_b = 1'b1;
            if (in_last) begin
              cmd.k_init = 1'b1;
              state_next = S_SUM;
            end
          end
        end
      end
      S_SUM: begin
        cmd.sum_rd = 1'b1;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.mac_rd = 1'b1;
        if (stat.mac_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          if (stat.final_k) begin
            cmd.clear       = 1'b1;
            a_complete_next = 1'b0;
            state_next      = S_LOAD;
          end else begin
            cmd.k_step = 1'b1;
            state_next = S_SUM;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      a_complete <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      a_complete <= a_complete_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

/* hdl/pasmu_dp.sv */
// datapath: coefficient stores, counts, sum/difference and multiply-accumulate
// depends on pasmu_pkg
`timescale 1ns / 1ps

module pasmu_dp import pasmu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  pasmu_cmd_t               cmd,
  input  logic signed [COEF_W-1:0] coefficient,
  output pasmu_stat_t              stat,
  output logic        [IDX_W-1:0]  power_index,
  output logic signed [SUM_W-1:0]  sum_coefficient,
  output logic signed [SUM_W-1:0]  difference_coefficient,
  output logic                     sum_valid,
  output logic signed [ACC_W-1:0]  product_coefficient,
  output logic                     last_result
);

  logic signed [COEF_W-1:0] mem_a [DEPTH];
  logic signed [COEF_W-1:0] mem_b [DEPTH];

  logic        [CNT_W-1:0]  count_a;
  logic        [CNT_W-1:0]  count_b;
  logic        [K_W-1:0]    k;
  logic        [K_W-1:0]    i;
  logic signed [COEF_W-1:0] rd_a;
  logic signed [COEF_W-1:0] rd_b;
  logic                     rd_sum;
  logic                     rd_mac;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  diff_r;
  logic                     valid_r;

  logic [CNT_W-1:0]         wa_a;
  logic                     wa_a_ok;
  logic [ADDR_W-1:0]        ra;
  logic [ADDR_W-1:0]        rb;
  logic [K_W-1:0]           kmi;
  logic [T_W-1:0]           k_w;
  logic [T_W-1:0]           ca_w;
  logic [T_W-1:0]           cb_w;
  logic [T_W-1:0]           la_w;
  logic [T_W-1:0]           lb_w;
  logic [T_W-1:0]           maxlen;
  logic [K_W-1:0]           i_lo;
  logic [K_W-1:0]           i_hi;
  logic signed [COEF_W-1:0] ak;
  logic signed [COEF_W-1:0] bk;
  logic signed [COEF_W-1:0] op_a;
  logic signed [COEF_W-1:0] op_b;
  logic                     k_ok;

  // an empty polynomial counts as one zero term
  assign k_w    = T_W'(k);
  assign ca_w   = T_W'(count_a);
  assign cb_w   = T_W'(count_b);
  assign la_w   = (count_a == '0) ? T_W'(1) : ca_w;
  assign lb_w   = (count_b == '0) ? T_W'(1) : cb_w;
  assign maxlen = (la_w > lb_w) ? la_w : lb_w;
  assign i_lo   = (k_w >= lb_w) ? K_W'(k_w - lb_w + T_W'(1)) : '0;
  assign i_hi   = (k_w < la_w) ? k : K_W'(la_w - T_W'(1));
  assign kmi    = k - i;

  assign wa_a    = cmd.new_a ? '0 : count_a;
  assign wa_a_ok = (CNT_W'(DEPTH) > wa_a);

  assign ra = cmd.sum_rd ? k[ADDR_W-1:0] : i[ADDR_W-1:0];
  assign rb = cmd.sum_rd ? k[ADDR_W-1:0] : kmi[ADDR_W-1:0];

  assign ak   = (k_w < ca_w) ? rd_a : '0;
  assign bk   = (k_w < cb_w) ? rd_b : '0;
  assign k_ok = (k_w < maxlen);
  assign op_a = (count_a == '0) ? '0 : rd_a;
  assign op_b = (count_b == '0) ? '0 : rd_b;

  assign stat.mac_last  = (i == i_hi);
  assign stat.pipe_busy = rd_mac || prod_vld;
  assign stat.final_k   = ((k_w + T_W'(2)) == (la_w + lb_w));

  // coefficient stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.wr_a && wa_a_ok) begin
      mem_a[wa_a[ADDR_W-1:0]] <= coefficient;
    end
    if (cmd.wr_b && (CNT_W'(DEPTH) > count_b)) begin
      mem_b[count_b[ADDR_W-1:0]] <= coefficient;
    end
    rd_a <= mem_a[ra];
    rd_b <= mem_b[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a  <= '0;
      count_b  <= '0;
      k        <= '0;
      rd_sum   <= 1'b0;
      rd_mac   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_sum   <= cmd.sum_rd;
      rd_mac   <= cmd.mac_rd;
      prod_vld <= rd_mac;
      if (cmd.wr_a) begin
        if (wa_a_ok) begin
          count_a <= wa_a + CNT_W'(1);
        end
        if (cmd.new_a) begin
          count_b <= '0;
        end
      end
      if (cmd.wr_b && (CNT_W'(DEPTH) > count_b)) begin
        count_b <= count_b + CNT_W'(1);
      end
      if (cmd.clear) begin
        count_a <= '0;
        count_b <= '0;
      end
      if (cmd.k_init) begin
        k <= '0;
      end else if (cmd.k_step) begin
        k <= k + K_W'(1);
      end
    end
  end

  // term index, product and accumulator
  always_ff @(posedge clk) begin
    if (cmd.sum_rd) begin
      i <= i_lo;
    end else if (cmd.mac_rd) begin
      i <= i + K_W'(1);
    end
    prod <= op_a * op_b;
    if (cmd.sum_rd) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
    if (rd_sum) begin
      sum_r   <= k_ok ? (SUM_W'(ak) + SUM_W'(bk)) : '0;
      diff_r  <= k_ok ? (SUM_W'(ak) - SUM_W'(bk)) : '0;
      valid_r <= k_ok;
    end
    if (cmd.out_load) begin
      power_index            <= IDX_W'(k);
      sum_coefficient        <= sum_r;
      difference_coefficient <= diff_r;
      sum_valid              <= valid_r;
      product_coefficient    <= acc;
      last_result            <= stat.final_k;
    end
  end

endmodule

/* hdl/polynomial_add_sub_multiply_unit.sv */
// loading: one coefficient per cycle; results follow the last coefficient of b
// each result sums its n product terms (at most 16) one after another in the single
// shared multiply-accumulate, fed by the registered store reads
// first result is power 0, which has one product term, after the closing request of b
// no request is taken while results are computed; a waiting result does not block loading
// rst is synchronous, active high: counts and control clear, stores keep their contents
`timescale 1ns / 1ps

module polynomial_add_sub_multiply_unit import pasmu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [COEF_W-1:0]     s_tdata,   // [15:0] coefficient
  input  logic                  s_tuser,   // [0] command (0 = a, 1 = b)
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [4:0] power_index, [21:5] sum_coefficient,
                                           // [38:22] difference_coefficient,
                                           // [74:39] product_coefficient, rest zero
  output logic                  m_tuser,   // [0] sum_valid
  output logic                  m_tlast    // last_result
);

  pasmu_cmd_t               cmd;
  pasmu_stat_t              stat;
  logic        [IDX_W-1:0]  power_index;
  logic signed [SUM_W-1:0]  sum_coefficient;
  logic signed [SUM_W-1:0]  difference_coefficient;
  logic signed [ACC_W-1:0]  product_coefficient;

  pasmu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sel    (s_tuser),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pasmu_dp u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .coefficient            (s_tdata),
    .stat                   (stat),
    .power_index            (power_index),
    .sum_coefficient        (sum_coefficient),
    .difference_coefficient (difference_coefficient),
    .sum_valid              (m_tuser),
    .product_coefficient    (product_coefficient),
    .last_result            (m_tlast)
  );

  assign m_tdata = {{PAD_W{1'b0}}, product_coefficient, difference_coefficient,
                    sum_coefficient, power_index};

endmodule

/* hdl/pasmu_chk.sv */
// port-level checker for the polynomial unit, bound to the top level
// depends on pasmu_pkg and polynomial_add_sub_multiply_unit_assert.svh
`timescale 1ns / 1ps
`include "polynomial_add_sub_multiply_unit_assert.svh"

module pasmu_chk import pasmu_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [COEF_W-1:0]     s_tdata,
  input logic                  s_tuser,
  input logic                  s_tlast,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  // a stalled request keeps its value
  `PASMU_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tuser) && $stable(s_tlast), "stalled request changed")

  // a stalled result keeps its value
  `PASMU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

  // outside both degrees the sum and difference read zero
  `PASMU_ASSERT_NOW(a_sum_zero, m_tvalid && !m_tuser, m_tdata[38:5] == 34'd0, "sum or difference set past max degree")

  // the constant term always lies within both degrees
  `PASMU_ASSERT_NOW(a_idx0_valid, m_tvalid && (m_tdata[4:0] == 5'd0), m_tuser, "power zero without sum_valid")

  // highest power is twice the maximum degree
  `PASMU_ASSERT_NOW(a_idx_range, m_tvalid, m_tdata[4:0] != 5'd31, "power index out of range")

endmodule

bind polynomial_add_sub_multiply_unit pasmu_chk u_pasmu_chk (.*);
